// ----- rtl/core/csr_spmv_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the csr spmv row accumulate unit
package csr_spmv_pkg;

  localparam int unsigned IDX_W          = 12;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned SUM_W          = 64;
  localparam int unsigned ROW_W          = 16;
  localparam int unsigned VECTOR_DEPTH   = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_NZ    = 2'd1,
    MODE_EMPTY = 2'd2
  } mode_e;

  typedef struct packed {
    logic                    is_nz;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] vec;
    logic                    row_end;
    logic                    matrix_last;
  } work_t;

endpackage

// ----- rtl/core/csr_spmv_front.sv -----
`timescale 1ns / 1ps
// front end: input accept, vector store, item classification
module csr_spmv_front import csr_spmv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [IDX_W-1:0]        index_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    row_last_i,
  input  logic                    matrix_last_i,
  output logic                    push_o,
  output work_t                   push_work_o,
  input  logic                    full_i
);

  logic [VAL_W-1:0] mem_q [VECTOR_DEPTH];

  logic                    s1_valid_q;
  logic                    s1_is_nz_q;
  logic signed [VAL_W-1:0] s1_value_q;
  logic signed [VAL_W-1:0] s1_vec_q;
  logic                    s1_row_end_q;
  logic                    s1_mlast_q;

  logic  accept;
  logic  is_work;
  mode_e mode;

  assign mode       = mode_e'(mode_i);
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    case (mode)
      MODE_NZ:    is_work = 1'b1;
      MODE_EMPTY: is_work = 1'b1;
      default:    is_work = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= is_work;
    end else if (push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode == MODE_LOAD)) begin
      mem_q[index_i] <= value_i;
    end
    if (accept && (mode == MODE_NZ)) begin
      s1_vec_q <= mem_q[index_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_is_nz_q   <= (mode == MODE_NZ);
      s1_value_q   <= value_i;
      s1_row_end_q <= (mode == MODE_EMPTY) || row_last_i;
      s1_mlast_q   <= matrix_last_i;
    end
  end

  assign push_work_o = '{is_nz:       s1_is_nz_q,
                         value:       s1_value_q,
                         vec:         s1_vec_q,
                         row_end:     s1_row_end_q,
                         matrix_last: s1_mlast_q};

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("front stalls with no pending item");

endmodule

// ----- rtl/core/csr_spmv_queue.sv -----
`timescale 1ns / 1ps
// short queue between front and back end
module csr_spmv_queue import csr_spmv_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t push_work_i,
  output logic  full_o,
  output logic  pop_valid_o,
  output work_t pop_work_o,
  input  logic  pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t              buf_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign full_o      = (count_q == CNT_W'(DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_work_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_work_i;
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/csr_spmv_back.sv -----
`timescale 1ns / 1ps
// back end: multiply, saturating row accumulate, result register
module csr_spmv_back import csr_spmv_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    pop_valid_i,
  input  work_t                   pop_work_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ROW_W-1:0]        row_index_o,
  output logic signed [SUM_W-1:0] row_sum_o,
  output logic                    saturated_o,
  output logic                    final_row_o
);

  logic                    prod_valid_q;
  logic signed [SUM_W-1:0] prod_q;
  logic                    prod_row_end_q;
  logic                    prod_mlast_q;

  logic signed [SUM_W-1:0] acc_q;
  logic                    ovf_q;
  logic [ROW_W-1:0]        row_cnt_q;

  logic                    out_valid_q;
  logic [ROW_W-1:0]        out_row_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic                    out_sat_q;
  logic                    out_final_q;

  logic                    acc_go, row_go, prod_load;
  logic signed [SUM_W-1:0] mul;
  logic signed [SUM_W:0]   sum;
  logic                    sum_ovf;
  logic signed [SUM_W-1:0] sum_sat;

  assign acc_go    = prod_valid_q && (!prod_row_end_q || !out_valid_q || !out_stall_i);
  assign row_go    = acc_go && prod_row_end_q;
  assign prod_load = !prod_valid_q || acc_go;
  assign pop_o     = pop_valid_i && prod_load;

  assign mul     = SUM_W'($signed(pop_work_i.value)) * SUM_W'($signed(pop_work_i.vec));
  assign sum     = {acc_q[SUM_W-1], acc_q} + {prod_q[SUM_W-1], prod_q};
  assign sum_ovf = sum[SUM_W] ^ sum[SUM_W-1];
  assign sum_sat = sum_ovf ? (sum[SUM_W] ? SUM_MIN : SUM_MAX) : sum[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_load) begin
      prod_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q         <= pop_work_i.is_nz ? mul : '0;
      prod_row_end_q <= pop_work_i.row_end;
      prod_mlast_q   <= pop_work_i.matrix_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      row_cnt_q <= '0;
    end else if (row_go) begin
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      row_cnt_q <= prod_mlast_q ? '0 : row_cnt_q + 1'b1;
    end else if (acc_go) begin
      acc_q <= sum_sat;
      ovf_q <= ovf_q | sum_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (row_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_go) begin
      out_row_q   <= row_cnt_q;
      out_sum_q   <= sum_sat;
      out_sat_q   <= ovf_q | sum_ovf;
      out_final_q <= prod_mlast_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = out_row_q;
  assign row_sum_o   = out_sum_q;
  assign saturated_o = out_sat_q;
  assign final_row_o = out_final_q;

  a_row_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_go |=> (acc_q == '0) && !ovf_q)
    else $error("accumulator not cleared after row end");

  a_final_resets_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_go && prod_mlast_q) |=> (row_cnt_q == '0))
    else $error("row counter not reset after final row");

endmodule

// ----- rtl/core/csr_spmv_row_accumulate_unit.sv -----
`timescale 1ns / 1ps
// top level of the csr spmv row accumulate unit
//
//   channel | direction | handshake              | beat fields
//   in      | input     | in_valid_i / in_stall_o | mode, index, value, row_last, matrix_last
//   out     | output    | out_valid_o / out_stall_i | row_index, row_sum, saturated, final_row
//
// one beat per cycle on each side while not stalled; after the accepting edge a row result
// passes in order through the input stage, queue, multiply register and accumulate/result register
// the single-port-write vector store and the running accumulator carry one item a cycle unless stalled
// reset clears control state and the accumulator; the vector store is not cleared
// an output stall holds the result register, then the back end, then the queue fills
// and only then is the input stalled
module csr_spmv_row_accumulate_unit import csr_spmv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              mode_i,
  input  logic [IDX_W-1:0]        index_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    row_last_i,
  input  logic                    matrix_last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ROW_W-1:0]        row_index_o,
  output logic signed [SUM_W-1:0] row_sum_o,
  output logic                    saturated_o,
  output logic                    final_row_o
);

  logic  push, full, pop_valid, pop;
  work_t push_work, pop_work;

  csr_spmv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .index_i       (index_i),
    .value_i       (value_i),
    .row_last_i    (row_last_i),
    .matrix_last_i (matrix_last_i),
    .push_o        (push),
    .push_work_o   (push_work),
    .full_i        (full)
  );

  csr_spmv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_work_i (push_work),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_work_o  (pop_work),
    .pop_i       (pop)
  );

  csr_spmv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_work_i  (pop_work),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .row_sum_o   (row_sum_o),
    .saturated_o (saturated_o),
    .final_row_o (final_row_o)
  );

endmodule
